>>> src/prd_pkg.sv
// shared constants and types for the pulse rate detector
// used by prd_div and pulse_rate_detector; no dependencies
package prd_pkg;

  localparam int PERIOD_W    = 16;
  localparam int LEVEL_W     = 12;
  localparam int LIMIT_W     = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int LED_W       = 8;

  localparam int AVG_DEPTH_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SUM_W_DEF       = PERIOD_W + $clog2(AVG_DEPTH_DEF);

  localparam int PERIOD_INIT = 428;

  localparam logic [LEVEL_W-1:0]  RISE_LEVEL_RST    = LEVEL_W'(2148);
  localparam logic [LEVEL_W-1:0]  FALL_LEVEL_RST    = LEVEL_W'(1948);
  localparam logic [LIMIT_W-1:0]  ALARM_LOW_RST     = LIMIT_W'(40);
  localparam logic [LIMIT_W-1:0]  ALARM_HIGH_RST    = LIMIT_W'(200);
  localparam logic [PERIOD_W-1:0] TIMEOUT_TICKS_RST = PERIOD_W'(1000);
  localparam logic [LED_W-1:0]    LED_TICKS_RST     = LED_W'(50);
  localparam logic [PERIOD_W-1:0] RATE_SCALE_RST    = PERIOD_W'(30000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LED_TICKS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE    = 3'd6;

  typedef struct packed {
    logic start;
    logic full;    // 1: run over the whole dividend, 0: only the top PERIOD_W bits
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/prd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on prd_pkg
module prd_div #(
  parameter int SUM_W = prd_pkg::SUM_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  prd_pkg::div_req_t            req,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [prd_pkg::PERIOD_W-1:0] divisor,
  output prd_pkg::div_rsp_t            rsp
);
  import prd_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]    num;
  logic [PERIOD_W-1:0] den;
  logic [PERIOD_W-1:0] part;
  logic [PERIOD_W-1:0] quo;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [PERIOD_W:0] trial;
  logic [PERIOD_W:0] diff;
  logic              fits;

  always_comb begin
    trial = {part, num[SUM_W-1]};
    fits  = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.full ? CNT_W'(SUM_W) : CNT_W'(PERIOD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= dividend;
      den  <= divisor;
      part <= '0;
      quo  <= '0;
    end else if (busy) begin
      num  <= num << 1;
      part <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quo  <= {quo[PERIOD_W-2:0], fits};
    end
  end

  // a zero divisor always fits, so the quotient comes out all ones
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> src/pulse_rate_detector.sv
// pulse rate detector: hysteresis beat finder, period average, rate and alarms
// usage:
//   in channel (in_valid/in_ready) takes one sample per sensor tick. each item
//   yields exactly one result on the out channel (out_valid/out_ready): rate,
//   new_beat, signal_lost, alarm and beat_led.
//   configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   unknown indexes are ignored.
// timing:
//   one item at a time. without a beat an accepted item runs through ST_PREP,
//   ST_RATE and ST_DONE to out_valid; a completed beat also runs the ring average
//   through the same divider in ST_AVG and ST_RSTART before ST_RATE. in_ready
//   returns with out_valid, so the next item waits for the previous result; the
//   bit-serial divider, one quotient bit per cycle, does both divisions.
// reset:
//   rst (synchronous) loads the configuration and detector state with defaults,
//   the period ring with 428 in every entry, and empties the output register.
// stalls:
//   a finished result sits in the output register until taken; the next item
//   is accepted meanwhile and its result waits in the core until the output
//   register frees up.
// depends on prd_pkg and prd_div
module pulse_rate_detector #(
  parameter int AVG_DEPTH   = prd_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = prd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prd_pkg::PERIOD_W-1:0]  rate,
  output logic                          new_beat,
  output logic                          signal_lost,
  output logic                          alarm,
  output logic                          beat_led,
  input  logic                          cfg_we,
  input  logic [prd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prd_pkg::CFG_W-1:0]     cfg_data
);
  import prd_pkg::*;

  localparam int SUM_W = PERIOD_W + $clog2(AVG_DEPTH);
  localparam int IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam logic [SUM_W-1:0]    SUM_INIT    = SUM_W'(PERIOD_INIT * AVG_DEPTH);
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(PERIOD_INIT);
  localparam logic [IDX_W-1:0]    IDX_LAST    = IDX_W'(AVG_DEPTH - 1);
  localparam logic [PERIOD_W-1:0] TICK_MAX    = '1;
  localparam logic [LED_W-1:0]    LED_MAX     = '1;

  // beat finder states
  localparam logic [1:0] BT_IDLE  = 2'd0;
  localparam logic [1:0] BT_ARMED = 2'd1;
  localparam logic [1:0] BT_LOW   = 2'd2;
  localparam logic [1:0] BT_HIGH  = 2'd3;

  // sequencer states
  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_AVG    = 3'd2;
  localparam logic [2:0] ST_RSTART = 3'd3;
  localparam logic [2:0] ST_RATE   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // configuration
  logic [LEVEL_W-1:0]  rise_level;
  logic [LEVEL_W-1:0]  fall_level;
  logic [LIMIT_W-1:0]  alarm_low;
  logic [LIMIT_W-1:0]  alarm_high;
  logic [PERIOD_W-1:0] timeout_ticks;
  logic [LED_W-1:0]    led_ticks;
  logic [PERIOD_W-1:0] rate_scale;

  // detector state
  logic [1:0]          beat_state;
  logic [PERIOD_W-1:0] tick_count;
  logic [PERIOD_W-1:0] period_ring [AVG_DEPTH];
  logic [IDX_W-1:0]    ring_index;
  logic [SUM_W-1:0]    period_sum;
  logic [PERIOD_W-1:0] period_average;
  logic [LED_W-1:0]    led_count;
  logic                led_on;

  logic [2:0]          st;
  logic                pend_beat;
  logic                pend_lost;
  logic                pend_led;
  logic [PERIOD_W-1:0] res_rate;
  logic                res_alarm;

  logic                accept;
  logic                out_free;
  logic [CMP_W-1:0]    smp;
  logic                above;
  logic                below;
  logic [PERIOD_W-1:0] tick_inc;
  logic [LED_W-1:0]    led_inc;
  logic [1:0]          beat_state_next;
  logic [PERIOD_W-1:0] tick_count_next;
  logic [LED_W-1:0]    led_count_next;
  logic                led_on_next;
  logic                beat;
  logic                lost;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [SUM_W-1:0]    div_dividend;
  logic [PERIOD_W-1:0] div_divisor;

  assign in_ready = (st == ST_WAIT);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_level    <= RISE_LEVEL_RST;
      fall_level    <= FALL_LEVEL_RST;
      alarm_low     <= ALARM_LOW_RST;
      alarm_high    <= ALARM_HIGH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
      led_ticks     <= LED_TICKS_RST;
      rate_scale    <= RATE_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RISE_LEVEL:    rise_level    <= cfg_data[LEVEL_W-1:0];
        REG_FALL_LEVEL:    fall_level    <= cfg_data[LEVEL_W-1:0];
        REG_ALARM_LOW:     alarm_low     <= cfg_data[LIMIT_W-1:0];
        REG_ALARM_HIGH:    alarm_high    <= cfg_data[LIMIT_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_LED_TICKS:     led_ticks     <= cfg_data[LED_W-1:0];
        REG_RATE_SCALE:    rate_scale    <= cfg_data;
        default: ;
      endcase
    end
  end

  // one tick of the beat finder
  always_comb begin
    smp      = CMP_W'(sample);
    above    = smp > CMP_W'(rise_level);
    below    = smp < CMP_W'(fall_level);
    tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;
    led_inc  = (led_count == LED_MAX) ? led_count : led_count + 1'b1;

    beat_state_next = beat_state;
    tick_count_next = tick_inc;
    led_count_next  = led_inc;
    led_on_next     = led_on;
    beat            = 1'b0;

    unique case (beat_state)
      BT_IDLE: begin
        if (above) beat_state_next = BT_ARMED;
      end
      BT_ARMED: begin
        if (below) begin
          beat_state_next = BT_LOW;
          tick_count_next = '0;
          led_on_next     = 1'b1;
          led_count_next  = '0;
        end
      end
      BT_LOW: begin
        if (led_inc >= led_ticks) led_on_next = 1'b0;
        if (above) beat_state_next = BT_HIGH;
      end
      BT_HIGH: begin
        if (below) begin
          beat_state_next = BT_LOW;
          tick_count_next = '0;
          led_on_next     = 1'b1;
          led_count_next  = '0;
          beat            = 1'b1;
        end
      end
      default: ;
    endcase

    lost = tick_count_next > timeout_ticks;
    if (lost) beat_state_next = BT_ARMED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_state     <= BT_IDLE;
      tick_count     <= '0;
      led_count      <= '0;
      led_on         <= 1'b0;
      ring_index     <= '0;
      period_sum     <= SUM_INIT;
      period_average <= PERIOD_RST;
      for (int i = 0; i < AVG_DEPTH; i++) period_ring[i] <= PERIOD_RST;
    end else begin
      if (accept) begin
        beat_state <= beat_state_next;
        tick_count <= tick_count_next;
        led_count  <= led_count_next;
        led_on     <= led_on_next;
        if (beat) begin
          // running sum: drop the oldest period, add the new one
          period_ring[ring_index] <= tick_inc;
          period_sum <= period_sum - SUM_W'(period_ring[ring_index]) + SUM_W'(tick_inc);
          ring_index <= (ring_index == IDX_LAST) ? '0 : ring_index + 1'b1;
        end
      end
      if (st == ST_AVG && div_rsp.done) period_average <= div_rsp.quotient;
    end
  end

  // divider requests: ring average after a beat, then the rate
  always_comb begin
    div_req.start = (st == ST_PREP) || (st == ST_RSTART);
    div_req.full  = (st == ST_PREP) && pend_beat;
    div_dividend  = div_req.full ? period_sum : (SUM_W'(rate_scale) << (SUM_W - PERIOD_W));
    div_divisor   = div_req.full ? PERIOD_W'(AVG_DEPTH) : period_average;
  end

  prd_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_WAIT;
      out_valid <= 1'b0;
    end else begin
      if (st == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st)
        ST_WAIT: begin
          if (accept) st <= ST_PREP;
        end
        ST_PREP: begin
          st <= pend_beat ? ST_AVG : ST_RATE;
        end
        ST_AVG: begin
          if (div_rsp.done) st <= ST_RSTART;
        end
        ST_RSTART: begin
          st <= ST_RATE;
        end
        ST_RATE: begin
          if (div_rsp.done) st <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) st <= ST_WAIT;
        end
        default: st <= ST_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_beat <= beat;
      pend_lost <= lost;
      pend_led  <= led_on_next;
    end
    if (st == ST_RATE && div_rsp.done) begin
      res_rate  <= div_rsp.quotient;
      res_alarm <= (div_rsp.quotient <= PERIOD_W'(alarm_low)) ||
                   (div_rsp.quotient >= PERIOD_W'(alarm_high));
    end
    if (st == ST_DONE && out_free) begin
      rate        <= res_rate;
      new_beat    <= pend_beat;
      signal_lost <= pend_lost;
      alarm       <= res_alarm;
      beat_led    <= pend_led;
    end
  end

endmodule
